>>> hw/rtl/ready_queue_with_sorted_insert_macros.svh
// Assertion macros shared by the ready queue RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef READY_QUEUE_WITH_SORTED_INSERT_MACROS_SVH
`define READY_QUEUE_WITH_SORTED_INSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RQSI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RQSI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/rqsi_pkg.sv
// Shared types and codes for the ready queue with sorted insert.
// Depends on nothing; used by the slot memory and the top level.
package rqsi_pkg;

    // One queue entry as it is stored in the slot memory.
    typedef struct packed {
        logic [15:0] pid;
        logic [9:0]  start;
        logic [9:0]  length;
        logic [9:0]  counter;
        logic [9:0]  score;
    } t_entry;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_INSERT     = 2'd2,
        OP_POP        = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

>>> hw/rtl/ready_queue_with_sorted_insert.sv
// Ready queue with sorted insert: top level, sequencer and head/count bookkeeping.
// Depends on rqsi_pkg, rqsi_slot_ram and ready_queue_with_sorted_insert_macros.svh.
//
// The queue holds up to QUEUE_DEPTH process entries in a circular slot memory addressed
// from a head pointer, so push back, push front and pop touch a single slot. Insert by
// score walks the queue from the head, one slot per cycle through the memory's single
// read port, and ripples the displaced entries one place toward the tail as it goes.
// One item is handled at a time and each produces exactly one result item; o_stall stays
// high from acceptance until the result has been taken, so a new item is not accepted
// before the last one is through.
// The result reports the popped entry or the head after the operation, plus the count.
// Slots are not cleared at reset; only held slots are ever read.
`include "ready_queue_with_sorted_insert_macros.svh"

module ready_queue_with_sorted_insert #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item channel.
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_entry_pid,
    input  logic [9:0]  i_entry_start,
    input  logic [9:0]  i_entry_length,
    input  logic [9:0]  i_entry_counter,
    input  logic [9:0]  i_entry_score,
    // Result item channel.
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_pid,
    output logic [9:0]  o_out_start,
    output logic [9:0]  o_out_length,
    output logic [9:0]  o_out_counter,
    output logic [9:0]  o_out_score,
    output logic        o_out_valid,
    output logic [4:0]  o_entries_held
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_POPW  = 6'b000010,
        S_WALK  = 6'b000100,
        S_HEAD  = 6'b001000,
        S_HEADW = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    // Physical slot of the entry that sits off places behind base, modulo the depth.
    function automatic logic [IW-1:0] f_phys(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
        logic [IW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (IW+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IW+1)'(QUEUE_DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    t_state               r_state, n_state;
    logic [IW-1:0]        r_head, n_head;
    logic [CW-1:0]        r_count, n_count;
    logic [IW-1:0]        r_k, n_k;
    logic                 r_pend, n_pend;
    logic                 r_ins, n_ins;
    rqsi_pkg::t_entry     r_carry, n_carry;
    rqsi_pkg::t_entry     r_out, n_out;
    logic                 r_out_valid, n_out_valid;
    rqsi_pkg::t_status    r_status, n_status;

    rqsi_pkg::t_entry     in_entry;
    rqsi_pkg::t_op        in_op;
    logic                 full;
    logic [IW-1:0]        idx_a;
    logic [IW-1:0]        phys_a;
    logic [IW-1:0]        phys_b;
    logic [IW-1:0]        head_dec;
    logic [IW-1:0]        head_inc;
    logic [CW+4:0]        count_ext;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    rqsi_pkg::t_entry     ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    rqsi_pkg::t_entry     ram_rdata;

    assign in_entry.pid     = i_entry_pid;
    assign in_entry.start   = i_entry_start;
    assign in_entry.length  = i_entry_length;
    assign in_entry.counter = i_entry_counter;
    assign in_entry.score   = i_entry_score;
    assign in_op            = rqsi_pkg::t_op'(i_operation);

    assign full = (r_count == CW'(QUEUE_DEPTH));

    // In idle the tail slot is addressed for push back; during the walk it is the read
    // index, which at the end of the walk is also the tail slot for the last write.
    assign idx_a  = (r_state == S_IDLE) ? r_count[IW-1:0] : r_k;
    assign phys_a = f_phys(r_head, idx_a);
    // The slot whose read data arrives this cycle lies one place behind the read index.
    assign phys_b = f_phys(r_head, r_k - 1'b1);

    assign head_dec = (r_head == '0) ? IW'(QUEUE_DEPTH - 1) : r_head - 1'b1;
    assign head_inc = (r_head == IW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_k         = r_k;
        n_pend      = r_pend;
        n_ins       = r_ins;
        n_carry     = r_carry;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        ram_we      = 1'b0;
        ram_waddr   = phys_a;
        ram_wdata   = r_carry;
        ram_re      = 1'b0;
        ram_raddr   = r_head;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_carry = in_entry;
                    n_k     = '0;
                    n_pend  = 1'b0;
                    n_ins   = 1'b0;
                    if (in_op == rqsi_pkg::OP_POP) begin
                        if (r_count == '0) begin
                            n_status    = rqsi_pkg::ST_EMPTY;
                            n_out       = '0;
                            n_out_valid = 1'b0;
                            n_state     = S_OUT;
                        end else begin
                            ram_re  = 1'b1;
                            n_state = S_POPW;
                        end
                    end else if (full) begin
                        n_status = rqsi_pkg::ST_FULL;
                        n_state  = S_HEAD;
                    end else begin
                        n_status = rqsi_pkg::ST_OK;
                        case (in_op)
                            rqsi_pkg::OP_PUSH_BACK: begin
                                ram_we    = 1'b1;
                                ram_waddr = phys_a;
                                ram_wdata = in_entry;
                                n_count   = r_count + 1'b1;
                                n_state   = S_HEAD;
                            end
                            rqsi_pkg::OP_PUSH_FRONT: begin
                                ram_we    = 1'b1;
                                ram_waddr = head_dec;
                                ram_wdata = in_entry;
                                n_head    = head_dec;
                                n_count   = r_count + 1'b1;
                                n_state   = S_HEAD;
                            end
                            default: begin
                                n_state = S_WALK;
                            end
                        endcase
                    end
                end
            end
            S_POPW: begin
                n_out       = ram_rdata;
                n_out_valid = 1'b1;
                n_status    = rqsi_pkg::ST_OK;
                n_head      = head_inc;
                n_count     = r_count - 1'b1;
                n_state     = S_OUT;
            end
            S_WALK: begin
                // Once the new entry has found its place, every later entry moves one
                // slot toward the tail, carried through r_carry.
                if (r_pend && (r_ins || (ram_rdata.score >= r_carry.score))) begin
                    ram_we    = 1'b1;
                    ram_waddr = phys_b;
                    ram_wdata = r_carry;
                    n_carry   = ram_rdata;
                    n_ins     = 1'b1;
                end
                if (CW'(r_k) != r_count) begin
                    ram_re    = 1'b1;
                    ram_raddr = phys_a;
                    n_k       = r_k + 1'b1;
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        ram_we    = 1'b1;
                        ram_waddr = phys_a;
                        ram_wdata = r_carry;
                        n_count   = r_count + 1'b1;
                        n_state   = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                ram_re    = 1'b1;
                ram_raddr = r_head;
                n_state   = S_HEADW;
            end
            S_HEADW: begin
                n_out       = ram_rdata;
                n_out_valid = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_k     <= '0;
            r_pend  <= 1'b0;
            r_ins   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_k     <= n_k;
            r_pend  <= n_pend;
            r_ins   <= n_ins;
        end
    end

    always_ff @(posedge i_clk) begin
        r_carry     <= n_carry;
        r_out       <= n_out;
        r_out_valid <= n_out_valid;
        r_status    <= n_status;
    end

    rqsi_slot_ram #(
        .DEPTH (QUEUE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The count field is five bits wide; a deeper queue reports it modulo 32.
    assign count_ext = {5'b0, r_count};

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = (r_state == S_OUT);
    assign o_status       = r_status;
    assign o_out_pid      = r_out.pid;
    assign o_out_start    = r_out.start;
    assign o_out_length   = r_out.length;
    assign o_out_counter  = r_out.counter;
    assign o_out_score    = r_out.score;
    assign o_out_valid    = r_out_valid;
    assign o_entries_held = count_ext[4:0];

    `RQSI_ASSERT_IMPL(a_count_in_range, i_clk, i_rst_n, 1'b1,
        r_count <= CW'(QUEUE_DEPTH), "queue count exceeds depth")
    `RQSI_ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, r_state == S_WALK,
        (CW'(r_k) <= r_count) && !full, "insert walk beyond held entries")
    `RQSI_ASSERT_IMPL(a_empty_report, i_clk, i_rst_n,
        o_valid && (r_status == rqsi_pkg::ST_EMPTY),
        !r_out_valid && (r_count == '0), "empty status with entries or valid report")
    `RQSI_ASSERT_IMPL(a_full_report, i_clk, i_rst_n,
        o_valid && (r_status == rqsi_pkg::ST_FULL),
        r_out_valid && full, "full status while queue not full")
    `RQSI_ASSERT_NEXT(a_pop_decrements, i_clk, i_rst_n, r_state == S_POPW,
        r_count == $past(r_count) - 1'b1, "pop did not lower the count by one")

endmodule

>>> hw/rtl/rqsi_slot_ram.sv
// Slot memory of the ready queue: one write port, one registered read port.
// Depends on rqsi_pkg for the entry type.
module rqsi_slot_ram #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  rqsi_pkg::t_entry         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output rqsi_pkg::t_entry         o_rdata
);

    rqsi_pkg::t_entry r_mem [DEPTH];
    rqsi_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data is registered: it is available in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
